FILE: src/us2cal_pkg.sv
// Package for the seconds-to-calendar converter.
// Holds time constants, month length table and tdata field widths.
// No dependencies.
package us2cal_pkg;

  localparam int unsigned SECS_PER_DAY  = 24 * 60 * 60;
  localparam int unsigned SECS_PER_HOUR = 3600;
  localparam int unsigned SECS_PER_MIN  = 60;
  localparam int unsigned EPOCH_YEAR    = 1970;
  localparam int unsigned LEAP_YEAR_LEN = 366;
  localparam int unsigned YEAR_LEN      = 365;

  // epoch year residues
  localparam int unsigned EPOCH_MOD4   = 2;
  localparam int unsigned EPOCH_MOD100 = 70;
  localparam int unsigned EPOCH_MOD400 = 370;

  localparam int unsigned IN_W  = 32;
  localparam int unsigned OUT_W = 40;

  typedef logic [4:0] mlen_t;

  function automatic mlen_t month_len(input logic [3:0] m, input logic leap);
    mlen_t len;
    case (m)
      4'd0:    len = 5'd31;
      4'd1:    len = leap ? 5'd29 : 5'd28;
      4'd2:    len = 5'd31;
      4'd3:    len = 5'd30;
      4'd4:    len = 5'd31;
      4'd5:    len = 5'd30;
      4'd6:    len = 5'd31;
      4'd7:    len = 5'd31;
      4'd8:    len = 5'd30;
      4'd9:    len = 5'd31;
      4'd10:   len = 5'd30;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

FILE: src/unix_seconds_to_calendar_core.sv
// Top level: unix seconds to Gregorian date and time of day.
// Uses us2cal_pkg for constants and the month length table.
//
// Usage:
//   Input channel in_*: one item is a 32-bit seconds count since
//   1970-01-01 00:00:00, local offset already applied.
//   Output channel out_*: one item per input, carrying day, month, year,
//   hour, minute and second.
//   One compare/subtract unit does all the work under a small sequencer:
//   16 restoring-division steps for days, 5 for hours, 6 for minutes,
//   then one step per whole year removed plus one, one step per whole
//   month removed plus one, and a load step into the output register.
//   in_tready is high only while idle, so a new item is accepted only
//   after the previous one has been loaded into the output register.
//   The finished item sits in an output register; if the receiver stalls,
//   the next item may still be accepted and computed, and then waits
//   until the register is taken.
//   Reset (rst_n low, synchronous) returns to idle and drops out_tvalid.
module unix_seconds_to_calendar_core
  import us2cal_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [IN_W-1:0]  in_tdata,   // [31:0] unix_seconds
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata   // [4:0] day_of_month, [8:5] month_number,
                                       // [20:9] year_number, [25:21] hour_of_day,
                                       // [31:26] minute_of_hour,
                                       // [37:32] second_of_minute, [39:38] zero
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DAY  = 3'd1;
  localparam logic [2:0] ST_HOUR = 3'd2;
  localparam logic [2:0] ST_MIN  = 3'd3;
  localparam logic [2:0] ST_YEAR = 3'd4;
  localparam logic [2:0] ST_MON  = 3'd5;
  localparam logic [2:0] ST_LOAD = 3'd6;

  logic [2:0]       state_r, state_nxt;
  logic [3:0]       k_r, k_nxt;
  logic [31:0]      rem_r, rem_nxt;
  logic [15:0]      q_r, q_nxt;
  logic [15:0]      days_r, days_nxt;
  logic [4:0]       hour_r, hour_nxt;
  logic [5:0]       min_r, min_nxt;
  logic [5:0]       sec_r, sec_nxt;
  logic [11:0]      year_r, year_nxt;
  logic [1:0]       mod4_r, mod4_nxt;
  logic [6:0]       mod100_r, mod100_nxt;
  logic [8:0]       mod400_r, mod400_nxt;
  logic [3:0]       mon_r, mon_nxt;
  logic [4:0]       dom_r, dom_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0] out_data_r, out_data_nxt;

  logic [31:0] sub_op;
  logic [32:0] diff;
  logic        ge;
  logic        leap;
  logic [15:0] q_shift;

  assign leap    = (mod400_r == 9'd0) || ((mod4_r == 2'd0) && (mod100_r != 7'd0));
  assign q_shift = {q_r[14:0], ge};

  // operand select for the shared subtractor
  always_comb begin
    case (state_r)
      ST_DAY:  sub_op = 32'(SECS_PER_DAY) << k_r;
      ST_HOUR: sub_op = 32'(SECS_PER_HOUR) << k_r;
      ST_MIN:  sub_op = 32'(SECS_PER_MIN) << k_r;
      ST_YEAR: sub_op = leap ? 32'(LEAP_YEAR_LEN) : 32'(YEAR_LEN);
      ST_MON:  sub_op = {27'd0, month_len(mon_r, leap)};
      default: sub_op = 32'd0;
    endcase
  end

  assign diff = {1'b0, rem_r} - {1'b0, sub_op};
  assign ge   = ~diff[32];

  always_comb begin
    state_nxt     = state_r;
    k_nxt         = k_r;
    rem_nxt       = rem_r;
    q_nxt         = q_r;
    days_nxt      = days_r;
    hour_nxt      = hour_r;
    min_nxt       = min_r;
    sec_nxt       = sec_r;
    year_nxt      = year_r;
    mod4_nxt      = mod4_r;
    mod100_nxt    = mod100_r;
    mod400_nxt    = mod400_r;
    mon_nxt       = mon_r;
    dom_nxt       = dom_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          rem_nxt   = in_tdata;
          q_nxt     = 16'd0;
          k_nxt     = 4'd15;
          state_nxt = ST_DAY;
        end
      end
      ST_DAY, ST_HOUR, ST_MIN: begin
        if (ge) begin
          rem_nxt = diff[31:0];
        end
        q_nxt = q_shift;
        k_nxt = k_r - 4'd1;
        if (k_r == 4'd0) begin
          q_nxt = 16'd0;
          case (state_r)
            ST_DAY: begin
              days_nxt  = q_shift;
              k_nxt     = 4'd4;
              state_nxt = ST_HOUR;
            end
            ST_HOUR: begin
              hour_nxt  = q_shift[4:0];
              k_nxt     = 4'd5;
              state_nxt = ST_MIN;
            end
            default: begin
              min_nxt    = q_shift[5:0];
              sec_nxt    = ge ? diff[5:0] : rem_r[5:0];
              rem_nxt    = {16'd0, days_r};
              year_nxt   = 12'(EPOCH_YEAR);
              mod4_nxt   = 2'(EPOCH_MOD4);
              mod100_nxt = 7'(EPOCH_MOD100);
              mod400_nxt = 9'(EPOCH_MOD400);
              state_nxt  = ST_YEAR;
            end
          endcase
        end
      end
      ST_YEAR: begin
        if (ge) begin
          rem_nxt    = diff[31:0];
          year_nxt   = year_r + 12'd1;
          mod4_nxt   = mod4_r + 2'd1;
          mod100_nxt = (mod100_r == 7'd99) ? 7'd0 : mod100_r + 7'd1;
          mod400_nxt = (mod400_r == 9'd399) ? 9'd0 : mod400_r + 9'd1;
        end else begin
          mon_nxt   = 4'd0;
          state_nxt = ST_MON;
        end
      end
      ST_MON: begin
        if ((mon_r == 4'd11) || !ge) begin
          dom_nxt   = rem_r[4:0] + 5'd1;
          state_nxt = ST_LOAD;
        end else begin
          rem_nxt = diff[31:0];
          mon_nxt = mon_r + 4'd1;
        end
      end
      ST_LOAD: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {2'd0, sec_r, min_r, hour_r, year_r, mon_r + 4'd1, dom_r};
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      k_r         <= 4'd0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      k_r         <= k_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r      <= rem_nxt;
    q_r        <= q_nxt;
    days_r     <= days_nxt;
    hour_r     <= hour_nxt;
    min_r      <= min_nxt;
    sec_r      <= sec_nxt;
    year_r     <= year_nxt;
    mod4_r     <= mod4_nxt;
    mod100_r   <= mod100_nxt;
    mod400_r   <= mod400_nxt;
    mon_r      <= mon_nxt;
    dom_r      <= dom_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> state_r == ST_DAY)
    else $error("accepted item did not start day division");

  a_mon_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_MON |-> mon_r <= 4'd11)
    else $error("month index out of range");

  a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_data_r[4:0] != 5'd0 && out_data_r[8:5] != 4'd0
                    && out_data_r[8:5] <= 4'd12 && out_data_r[20:9] >= 12'(EPOCH_YEAR)
                    && out_data_r[25:21] <= 5'd23)
    else $error("result field out of range");

  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_tready |=> out_valid_r && $stable(out_data_r))
    else $error("pending result changed before it was taken");

  a_tod_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_HOUR && k_r == 4'd4 |-> rem_r < 32'(SECS_PER_DAY))
    else $error("time of day not below one day");

endmodule
